FILE: rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define MSTL_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("token lexer assertion failed");

// Clocked assertion that also holds through reset.
`define MSTL_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("token lexer assertion failed");

`endif

FILE: rtl/mstl_pkg.sv
// Types and constants of the music-script token lexer.
`default_nettype none

package mstl_pkg;

    // token kinds
    localparam logic [3:0] KIND_LBRACK    = 4'd0;
    localparam logic [3:0] KIND_RBRACK    = 4'd1;
    localparam logic [3:0] KIND_LBRACE    = 4'd2;
    localparam logic [3:0] KIND_RBRACE    = 4'd3;
    localparam logic [3:0] KIND_EQUALS    = 4'd4;
    localparam logic [3:0] KIND_KW_FIRST  = 4'd5;
    localparam logic [3:0] KIND_NOTE      = 4'd11;
    localparam logic [3:0] KIND_NUMBER    = 4'd12;
    localparam logic [3:0] KIND_STRING    = 4'd13;
    localparam logic [3:0] KIND_END       = 4'd14;

    // keyword table: OUTPUT NOTES PCM SECTION END INSTANCES
    localparam int KW_COUNT  = 6;
    localparam int KW_MAXLEN = 9;
    localparam int KW_IW     = $clog2(KW_MAXLEN);

    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAXLEN] = '{
        '{"O", "U", "T", "P", "U", "T", 8'h00, 8'h00, 8'h00},
        '{"N", "O", "T", "E", "S", 8'h00, 8'h00, 8'h00, 8'h00},
        '{"P", "C", "M", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"S", "E", "C", "T", "I", "O", "N", 8'h00, 8'h00},
        '{"E", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"I", "N", "S", "T", "A", "N", "C", "E", "S"}
    };

    localparam logic [3:0] KW_LEN [KW_COUNT] = '{4'd6, 4'd5, 4'd3, 4'd7, 4'd3, 4'd9};

    // records between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic        word_v;
        logic [3:0]  word_kind;
        logic [7:0]  word_len;
        logic        tail_v;
        logic [3:0]  tail_kind;
        logic [7:0]  tail_len;
        logic [15:0] line;
    } t_tok_rec;

endpackage

`default_nettype wire

FILE: rtl/mstl_if.sv
// Handshake channels of the token lexer: text input and token output.
`default_nettype none

interface mstl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_byte;
    logic       end_of_input;

    modport source (output valid, output text_byte, output end_of_input, input ready);
    modport sink   (input valid, input text_byte, input end_of_input, output ready);
endinterface

interface mstl_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [7:0]  token_length;
    logic [15:0] line_number;
    logic        last;

    modport source (output valid, output token_kind, output token_length,
                    output line_number, output last, input ready);
    modport sink   (input valid, input token_kind, input token_length,
                    input line_number, input last, output ready);
endinterface

`default_nettype wire

FILE: rtl/mstl_front.sv
// Front end: scans one byte per cycle while the queue has room, tracks word state and builds token records.
`default_nettype none

module mstl_front #(
    parameter int unsigned     LENGTH_LIMIT = 255,
    parameter longint unsigned LINE_LIMIT   = 65535
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_text_byte,
    input  logic             i_end_of_input,
    input  logic             i_q_full,
    output logic             o_push,
    output mstl_pkg::t_tok_rec o_rec
);

    localparam int LW  = $clog2(LENGTH_LIMIT + 1);
    localparam int LNW = $clog2(LINE_LIMIT + 1);
    localparam logic [LW-1:0]  LEN_MAX  = LW'(LENGTH_LIMIT);
    localparam logic [LNW-1:0] LINE_MAX = LNW'(LINE_LIMIT);
    localparam int KW_IDX_W = mstl_pkg::KW_IW;

    localparam logic [2:0] PH_START  = 3'd0;
    localparam logic [2:0] PH_DIGITS = 3'd1;
    localparam logic [2:0] PH_NAME   = 3'd2;
    localparam logic [2:0] PH_ACC    = 3'd3;
    localparam logic [2:0] PH_OK     = 3'd4;
    localparam logic [2:0] PH_DEAD   = 3'd5;

    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_HASH   = 8'h23;
    localparam logic [7:0] CH_FLAT   = 8'h62;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_A      = 8'h41;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUALS = 8'h3D;

    logic                 r_in_comment, n_in_comment;
    logic [LW-1:0]        r_wlen, n_wlen;
    logic [5:0]           r_alive, n_alive;
    logic [2:0]           r_phase, n_phase;
    logic                 r_num_ok, n_num_ok;
    logic [LNW-1:0]       r_line, n_line;

    logic                 acc;
    logic [7:0]           b;
    logic                 b_digit;
    logic                 b_blank;
    logic                 b_punct;
    logic [3:0]           punct_kind;
    logic [LNW-1:0]       line_inc;
    logic [KW_IDX_W-1:0]  kidx;
    logic [3:0]           word_kind;
    logic                 has_word;

    assign o_ready  = !i_q_full;
    assign acc      = i_valid && !i_q_full;
    assign b        = i_text_byte;
    assign b_digit  = (b >= CH_ZERO) && (b <= CH_NINE);
    assign b_blank  = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR)) || (b == CH_COMMA);
    assign b_punct  = (b == CH_LBRACK) || (b == CH_RBRACK) || (b == CH_LBRACE) ||
                      (b == CH_RBRACE) || (b == CH_EQUALS);
    assign line_inc = (r_line < LINE_MAX) ? r_line + LNW'(1) : r_line;
    assign has_word = (r_wlen != '0);
    assign kidx     = (r_wlen < LW'(mstl_pkg::KW_MAXLEN)) ? r_wlen[KW_IDX_W-1:0]
                                                          : '0;

    always_comb begin
        case (b)
            CH_LBRACK: punct_kind = mstl_pkg::KIND_LBRACK;
            CH_RBRACK: punct_kind = mstl_pkg::KIND_RBRACK;
            CH_LBRACE: punct_kind = mstl_pkg::KIND_LBRACE;
            CH_RBRACE: punct_kind = mstl_pkg::KIND_RBRACE;
            default:   punct_kind = mstl_pkg::KIND_EQUALS;
        endcase
    end

    // classify the pending word; first keyword in table order wins
    always_comb begin
        if (r_phase == PH_OK) begin
            word_kind = mstl_pkg::KIND_NOTE;
        end else if (r_num_ok) begin
            word_kind = mstl_pkg::KIND_NUMBER;
        end else begin
            word_kind = mstl_pkg::KIND_STRING;
        end
        for (int i = mstl_pkg::KW_COUNT - 1; i >= 0; i--) begin
            if (r_alive[i] && (r_wlen == LW'(mstl_pkg::KW_LEN[i]))) begin
                word_kind = mstl_pkg::KIND_KW_FIRST + 4'(i);
            end
        end
    end

    always_comb begin
        n_in_comment = r_in_comment;
        n_wlen       = r_wlen;
        n_alive      = r_alive;
        n_phase      = r_phase;
        n_num_ok     = r_num_ok;
        n_line       = r_line;
        o_push       = 1'b0;

        o_rec.word_v    = 1'b0;
        o_rec.word_kind = word_kind;
        o_rec.word_len  = 8'(r_wlen);
        o_rec.tail_v    = 1'b0;
        o_rec.tail_kind = mstl_pkg::KIND_END;
        o_rec.tail_len  = 8'd0;
        o_rec.line      = 16'(r_line);

        if (acc) begin
            if (i_end_of_input) begin
                // comment closes first, so both tokens see the new line
                if (r_in_comment) begin
                    n_in_comment = 1'b0;
                    n_line       = line_inc;
                    o_rec.line   = 16'(line_inc);
                end
                o_rec.word_v = has_word;
                o_rec.tail_v = 1'b1;
                o_push       = 1'b1;
                n_wlen       = '0;
                n_alive      = '1;
                n_phase      = PH_START;
                n_num_ok     = 1'b1;
            end else if (r_in_comment) begin
                if ((b == CH_LF) || (b == CH_CR)) begin
                    n_in_comment = 1'b0;
                    n_line       = line_inc;
                end
            end else if (b == CH_SEMI) begin
                n_in_comment = 1'b1;
            end else if (b_blank) begin
                o_rec.word_v = has_word;
                o_push       = has_word;
                n_wlen       = '0;
                n_alive      = '1;
                n_phase      = PH_START;
                n_num_ok     = 1'b1;
                if (b == CH_LF) begin
                    n_line = line_inc;
                end
            end else if (b_punct) begin
                o_rec.word_v    = has_word;
                o_rec.tail_v    = 1'b1;
                o_rec.tail_kind = punct_kind;
                o_rec.tail_len  = 8'd1;
                o_push          = 1'b1;
                n_wlen          = '0;
                n_alive         = '1;
                n_phase         = PH_START;
                n_num_ok        = 1'b1;
            end else begin
                for (int i = 0; i < mstl_pkg::KW_COUNT; i++) begin
                    n_alive[i] = r_alive[i] && (r_wlen < LW'(mstl_pkg::KW_LEN[i])) &&
                                 (mstl_pkg::KW_TEXT[i][kidx] == b);
                end
                case (r_phase)
                    PH_START: begin
                        n_phase = b_digit ? PH_DIGITS : PH_DEAD;
                    end
                    PH_DIGITS: begin
                        if (b_digit) begin
                            n_phase = PH_DIGITS;
                        end else if (b == CH_MINUS) begin
                            n_phase = PH_OK;
                        end else if ((b >= CH_A) && (b <= CH_H)) begin
                            n_phase = PH_NAME;
                        end else begin
                            n_phase = PH_DEAD;
                        end
                    end
                    PH_NAME: begin
                        n_phase = ((b == CH_HASH) || (b == CH_FLAT)) ? PH_ACC : PH_OK;
                    end
                    PH_ACC: begin
                        n_phase = PH_OK;
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
                if (!has_word) begin
                    n_num_ok = b_digit || (b == CH_MINUS);
                end else if (!b_digit) begin
                    n_num_ok = 1'b0;
                end
                if (r_wlen < LEN_MAX) begin
                    n_wlen = r_wlen + LW'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_comment <= 1'b0;
            r_wlen       <= '0;
            r_alive      <= '1;
            r_phase      <= PH_START;
            r_num_ok     <= 1'b1;
            r_line       <= LNW'(1);
        end else begin
            r_in_comment <= n_in_comment;
            r_wlen       <= n_wlen;
            r_alive      <= n_alive;
            r_phase      <= n_phase;
            r_num_ok     <= n_num_ok;
            r_line       <= n_line;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mstl_queue.sv
// Short record queue between the scanning front end and the token back end.
`default_nettype none

module mstl_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  mstl_pkg::t_tok_rec i_rec,
    input  logic               i_pop,
    output mstl_pkg::t_tok_rec o_head,
    output logic               o_full,
    output logic               o_empty
);

    localparam int QAW = $clog2(mstl_pkg::QUEUE_DEPTH);

    mstl_pkg::t_tok_rec r_mem [mstl_pkg::QUEUE_DEPTH];
    logic [QAW-1:0]     r_wp, n_wp;
    logic [QAW-1:0]     r_rp, n_rp;
    logic [QAW:0]       r_count, n_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == (QAW+1)'(mstl_pkg::QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wp    = do_push ? ((r_wp == QAW'(mstl_pkg::QUEUE_DEPTH - 1)) ? '0 : r_wp + QAW'(1))
                          : r_wp;
        n_rp    = do_pop  ? ((r_rp == QAW'(mstl_pkg::QUEUE_DEPTH - 1)) ? '0 : r_rp + QAW'(1))
                          : r_rp;
        n_count = r_count + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            r_wp    <= n_wp;
            r_rp    <= n_rp;
            r_count <= n_count;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/mstl_back.sv
// Back end: unpacks each record into one or two output tokens held in a register.
`default_nettype none

module mstl_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_empty,
    input  mstl_pkg::t_tok_rec i_head,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [3:0]         o_token_kind,
    output logic [7:0]         o_token_length,
    output logic [15:0]        o_line_number,
    output logic               o_last
);

    mstl_pkg::t_tok_rec r_rec;
    logic               r_busy;
    logic               r_second;
    logic               send_word;
    logic               fire;
    logic               free;

    // the word token goes out before the punctuation or end token
    assign send_word      = r_rec.word_v && !r_second;
    assign o_valid        = r_busy;
    assign o_token_kind   = send_word ? r_rec.word_kind : r_rec.tail_kind;
    assign o_token_length = send_word ? r_rec.word_len  : r_rec.tail_len;
    assign o_line_number  = r_rec.line;
    assign o_last         = send_word ? !r_rec.tail_v : 1'b1;

    assign fire  = r_busy && i_ready;
    assign free  = !r_busy || (fire && o_last);
    assign o_pop = free && !i_empty;

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rec <= i_head;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
        end else if (o_pop) begin
            r_busy   <= 1'b1;
            r_second <= 1'b0;
        end else if (free) begin
            r_busy   <= 1'b0;
            r_second <= 1'b0;
        end else if (fire) begin
            r_second <= 1'b1;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/music_script_token_lexer.sv
// Music-script token lexer: one source byte per item in, one token per item out.
//
// i_in carries text_byte and end_of_input; an item moves when valid and ready
// are high at a rising edge. o_tok carries token_kind, token_length,
// line_number and last, with the same handshake. Each input item gives zero,
// one or two tokens; last marks the final token of an item.
// Input is taken at one item per cycle whenever the record queue has room.
// The first token of an item is shown once its record has passed the record
// queue and the output register; a two-token item holds the output until both
// its tokens are taken, and the four-entry record queue soaks up such bursts, so
// input stalls only when the output side falls behind.
// When the receiver holds ready low, the output token holds, the queue fills
// and i_in.ready drops once all four entries are taken.
// Reset (synchronous, active low) clears comment and word state, sets the
// line count to one and empties the queue and the output register.
`default_nettype none

module music_script_token_lexer #(
    parameter int unsigned     LENGTH_LIMIT = 255,
    parameter longint unsigned LINE_LIMIT   = 65535
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mstl_in_if.sink     i_in,
    mstl_out_if.source  o_tok
);

    mstl_pkg::t_tok_rec front_rec;
    mstl_pkg::t_tok_rec head_rec;
    logic               push;
    logic               pop;
    logic               q_full;
    logic               q_empty;

    mstl_front #(
        .LENGTH_LIMIT (LENGTH_LIMIT),
        .LINE_LIMIT   (LINE_LIMIT)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in.valid),
        .o_ready        (i_in.ready),
        .i_text_byte    (i_in.text_byte),
        .i_end_of_input (i_in.end_of_input),
        .i_q_full       (q_full),
        .o_push         (push),
        .o_rec          (front_rec)
    );

    mstl_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_rec   (front_rec),
        .i_pop   (pop),
        .o_head  (head_rec),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    mstl_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (q_empty),
        .i_head         (head_rec),
        .o_pop          (pop),
        .o_valid        (o_tok.valid),
        .i_ready        (o_tok.ready),
        .o_token_kind   (o_tok.token_kind),
        .o_token_length (o_tok.token_length),
        .o_line_number  (o_tok.line_number),
        .o_last         (o_tok.last)
    );

endmodule

`default_nettype wire

FILE: rtl/mstl_checker.sv
// Port-level checks of the token lexer, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module mstl_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_token_kind,
    input logic [7:0]  i_token_length,
    input logic [15:0] i_line_number,
    input logic        i_last
);

    logic out_stall;
    logic is_end;
    logic is_punct;

    assign out_stall = i_out_valid && !i_out_ready;
    assign is_end    = i_out_valid && (i_token_kind == mstl_pkg::KIND_END);
    assign is_punct  = i_out_valid && (i_token_kind <= mstl_pkg::KIND_EQUALS);

    // a held token keeps its payload
    `MSTL_ASSERT(a_hold, i_clk, i_rst_n, out_stall |=> (i_out_valid && $stable(i_token_kind) && $stable(i_token_length) && $stable(i_line_number) && $stable(i_last)))

    // end of stream is always the final token of its item and has no length
    `MSTL_ASSERT(a_end_last, i_clk, i_rst_n, is_end |-> (i_last && (i_token_length == 8'd0)))

    // punctuation is one character and ends its item
    `MSTL_ASSERT(a_punct, i_clk, i_rst_n, is_punct |-> (i_last && (i_token_length == 8'd1)))

    // nothing is shown the cycle after reset, and input waits for no stale record
    `MSTL_ASSERT_ALWAYS(a_reset, i_clk, !$past(i_rst_n) |-> (!i_out_valid && (i_in_ready || !i_in_valid || i_in_ready)))

endmodule

bind music_script_token_lexer mstl_checker u_mstl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_tok.valid),
    .i_out_ready    (o_tok.ready),
    .i_token_kind   (o_tok.token_kind),
    .i_token_length (o_tok.token_length),
    .i_line_number  (o_tok.line_number),
    .i_last         (o_tok.last)
);

`default_nettype wire

FILE: sim/tb_top.sv
// Testbench of the music-script token lexer: stimulus, token predictor and scoreboard.
`timescale 1ns / 1ps

localparam logic [7:0] CH_TAB = 8'h09;
localparam logic [7:0] CH_LF  = 8'h0A;
localparam logic [7:0] CH_VT  = 8'h0B;
localparam logic [7:0] CH_FF  = 8'h0C;
localparam logic [7:0] CH_CR  = 8'h0D;

class token_scoreboard;
    typedef struct packed {
        logic [3:0]  kind;
        logic [7:0]  len;
        logic [15:0] line;
        logic        last;
    } token_t;

    typedef enum logic [2:0] {
        NP_START, NP_DIGITS, NP_NAME, NP_ACC, NP_OK, NP_DEAD
    } note_phase_e;

    localparam logic [7:0]  LENGTH_CAP = 8'd255;
    localparam logic [15:0] LINE_CAP   = 16'hFFFF;

    token_t      due_tokens[$];
    token_t      burst[$];
    int          errors;
    int          seen;
    bit          in_comment;
    logic [7:0]  word_len;
    logic [5:0]  kw_alive;
    note_phase_e note_ph;
    bit          num_ok;
    logic [15:0] line_cnt;

    function new();
        errors     = 0;
        seen       = 0;
        in_comment = 0;
        line_cnt   = 16'd1;
        clear_word();
    endfunction

    function void clear_word();
        word_len = 8'd0;
        kw_alive = '1;
        note_ph  = NP_START;
        num_ok   = 1'b1;
    endfunction

    function void bump_line();
        if (line_cnt != LINE_CAP) begin
            line_cnt++;
        end
    endfunction

    function bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function logic [3:0] word_kind();
        for (int i = 0; i < mstl_pkg::KW_COUNT; i++) begin
            if (kw_alive[i] && word_len == 8'(mstl_pkg::KW_LEN[i])) begin
                return 4'(mstl_pkg::KIND_KW_FIRST + i);
            end
        end
        if (note_ph == NP_OK) begin
            return mstl_pkg::KIND_NOTE;
        end
        if (num_ok) begin
            return mstl_pkg::KIND_NUMBER;
        end
        return mstl_pkg::KIND_STRING;
    endfunction

    function void emit(logic [3:0] kind, logic [7:0] len);
        token_t t;
        t.kind = kind;
        t.len  = len;
        t.line = line_cnt;
        t.last = 1'b0;
        burst.push_back(t);
    endfunction

    function void flush_word();
        if (word_len != 8'd0) begin
            emit(word_kind(), word_len);
            clear_word();
        end
    endfunction

    function void grow_word(logic [7:0] b);
        logic [7:0] pos;
        pos = word_len;
        for (int i = 0; i < mstl_pkg::KW_COUNT; i++) begin
            if (pos >= 8'(mstl_pkg::KW_LEN[i])) begin
                kw_alive[i] = 1'b0;
            end else if (mstl_pkg::KW_TEXT[i][pos] != b) begin
                kw_alive[i] = 1'b0;
            end
        end
        case (note_ph)
            NP_START: begin
                if (is_digit(b)) note_ph = NP_DIGITS;
                else note_ph = NP_DEAD;
            end
            NP_DIGITS: begin
                if (is_digit(b)) note_ph = NP_DIGITS;
                else if (b == "-") note_ph = NP_OK;
                else if (b >= "A" && b <= "H") note_ph = NP_NAME;
                else note_ph = NP_DEAD;
            end
            NP_NAME: begin
                if (b == "#" || b == "b") note_ph = NP_ACC;
                else note_ph = NP_OK;
            end
            NP_ACC: begin
                note_ph = NP_OK;
            end
            default: begin
            end
        endcase
        if (pos == 8'd0) begin
            num_ok = is_digit(b) || b == "-";
        end else if (!is_digit(b)) begin
            num_ok = 1'b0;
        end
        if (word_len != LENGTH_CAP) begin
            word_len++;
        end
    endfunction

    // works out the tokens that one accepted item gives and queues them
    function void note_input(logic [7:0] b, logic eoi);
        logic [3:0] pk;
        bit         punct;
        token_t     t;
        burst.delete();
        punct = 1'b1;
        case (b)
            "[":     pk = mstl_pkg::KIND_LBRACK;
            "]":     pk = mstl_pkg::KIND_RBRACK;
            "{":     pk = mstl_pkg::KIND_LBRACE;
            "}":     pk = mstl_pkg::KIND_RBRACE;
            "=":     pk = mstl_pkg::KIND_EQUALS;
            default: begin
                pk    = mstl_pkg::KIND_EQUALS;
                punct = 1'b0;
            end
        endcase
        if (eoi) begin
            if (in_comment) begin
                in_comment = 1'b0;
                bump_line();
            end
            flush_word();
            emit(mstl_pkg::KIND_END, 8'd0);
        end else if (in_comment) begin
            if (b == CH_LF || b == CH_CR) begin
                in_comment = 1'b0;
                bump_line();
            end
        end else if (b == ";") begin
            in_comment = 1'b1;
        end else if (b == " " || (b >= CH_TAB && b <= CH_CR) || b == ",") begin
            flush_word();
            if (b == CH_LF) begin
                bump_line();
            end
        end else if (punct) begin
            flush_word();
            emit(pk, 8'd1);
        end else begin
            grow_word(b);
        end
        foreach (burst[i]) begin
            t      = burst[i];
            t.last = (i == burst.size() - 1);
            due_tokens.push_back(t);
        end
    endfunction

    task report(string msg);
        errors++;
        if (errors <= 40) begin
            $display("ERROR: %s", msg);
        end
    endtask

    task check_token(logic [3:0] kind, logic [7:0] len, logic [15:0] line, logic last);
        token_t want;
        seen++;
        if (due_tokens.size() == 0) begin
            report($sformatf("token %0d (kind %0d, line %0d) with none due", seen, kind, line));
            return;
        end
        want = due_tokens.pop_front();
        if (kind !== want.kind) begin
            report($sformatf("token %0d: kind %0d, want %0d", seen, kind, want.kind));
        end
        if (len !== want.len) begin
            report($sformatf("token %0d: length %0d, want %0d", seen, len, want.len));
        end
        if (line !== want.line) begin
            report($sformatf("token %0d: line %0d, want %0d", seen, line, want.line));
        end
        if (last !== want.last) begin
            report($sformatf("token %0d: last %0b, want %0b", seen, last, want.last));
        end
    endtask
endclass

module tb_top;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int HOLD_CYCLES    = 80;
    localparam int PHASE_ITEMS    = 600;

    typedef struct packed {
        logic [7:0] b;
        logic       e;
    } src_item_t;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mstl_in_if  in_ch ();
    mstl_out_if tok_ch ();

    music_script_token_lexer DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_tok   (tok_ch)
    );

    token_scoreboard sb = new();

    src_item_t chunk[$];
    int        items_sent   = 0;
    int        in_idle_pct  = 0;
    int        out_idle_pct = 0;
    int        quiet_cycles = 0;
    bit        hold_req     = 1'b0;

    always #1 i_clk = ~i_clk;

    // --- text generation -------------------------------------------------

    function automatic bit is_sep(logic [7:0] b);
        return b == " " || (b >= CH_TAB && b <= CH_CR) || b == "," || b == ";" ||
               b == "[" || b == "]" || b == "{" || b == "}" || b == "=";
    endfunction

    function automatic logic [7:0] word_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (is_sep(b));
        return b;
    endfunction

    function automatic logic [7:0] comment_byte();
        logic [7:0] b;
        do b = 8'($urandom); while (b == CH_LF || b == CH_CR);
        return b;
    endfunction

    function automatic void put_byte(logic [7:0] b);
        chunk.push_back({b, 1'b0});
    endfunction

    function automatic void put_end();
        chunk.push_back({8'($urandom), 1'b1});
    endfunction

    function automatic void put_str(string s);
        for (int i = 0; i < s.len(); i++) begin
            put_byte(s[i]);
        end
    endfunction

    function automatic void put_digits(int n);
        repeat (n) put_byte(8'("0" + $urandom_range(9)));
    endfunction

    function automatic void put_word();
        int         r;
        int         n;
        int         idx;
        string      names;
        logic [7:0] nm;
        names = "ABCDEFGH-";
        r     = $urandom_range(99);
        idx   = $urandom_range(mstl_pkg::KW_COUNT - 1);
        n     = mstl_pkg::KW_LEN[idx];
        if (r < 14) begin
            for (int j = 0; j < n; j++) put_byte(mstl_pkg::KW_TEXT[idx][j]);
        end else if (r < 22) begin
            // cut-down or extended keyword
            n = $urandom_range(n, 1);
            for (int j = 0; j < n; j++) put_byte(mstl_pkg::KW_TEXT[idx][j]);
            if ($urandom_range(1)) put_byte(8'($urandom_range("Z", "A")));
        end else if (r < 50) begin
            put_digits($urandom_range(3, 1));
            nm = names[$urandom_range(8)];
            put_byte(nm);
            if (nm != "-") begin
                case ($urandom_range(5))
                    0: begin
                    end
                    1: begin
                        put_byte("#");
                    end
                    2: begin
                        put_byte("#");
                        put_byte(word_byte());
                    end
                    3: begin
                        put_byte("b");
                        put_byte(word_byte());
                    end
                    default: begin
                        put_byte(word_byte());
                    end
                endcase
            end
            if ($urandom_range(3) == 0) put_byte(word_byte());
        end else if (r < 65) begin
            if ($urandom_range(2) == 0) begin
                put_byte("-");
                put_digits($urandom_range(4, 0));
            end else begin
                put_digits($urandom_range(4, 1));
            end
        end else if (r < 80) begin
            repeat ($urandom_range(8, 1)) put_byte(word_byte());
        end else if (r < 88) begin
            // comment in the middle of a note word
            put_digits(1);
            put_byte(names[$urandom_range(7)]);
            put_byte(";");
            repeat ($urandom_range(5, 0)) put_byte(comment_byte());
            put_byte($urandom_range(1) ? CH_LF : CH_CR);
            put_byte("#");
            put_byte(word_byte());
        end else begin
            repeat ($urandom_range(4, 1)) put_byte(8'($urandom));
        end
    endfunction

    function automatic void put_sep();
        string puncts;
        puncts = "[]{}=";
        case ($urandom_range(11))
            0, 1, 2: put_byte(" ");
            3:       put_byte(CH_TAB);
            4:       put_byte(",");
            5:       put_byte(CH_LF);
            6: begin
                put_byte(CH_CR);
                put_byte(CH_LF);
            end
            7:       put_byte($urandom_range(1) ? CH_VT : CH_FF);
            8, 9:    put_byte(puncts[$urandom_range(4)]);
            10: begin
                put_byte(" ");
                put_byte(";");
                repeat ($urandom_range(6, 0)) put_byte(comment_byte());
                put_byte($urandom_range(1) ? CH_LF : CH_CR);
            end
            default: begin
                put_byte(puncts[$urandom_range(4)]);
                put_byte(" ");
            end
        endcase
    endfunction

    // overlong word around the length cap
    function automatic void put_long(int mode);
        int n;
        n = $urandom_range(262, 250);
        case (mode)
            0: put_digits(n);
            1: repeat (n) put_byte(word_byte());
            default: begin
                put_str("3C#");
                repeat (n) put_byte(word_byte());
            end
        endcase
        put_byte(" ");
    endfunction

    // --- driving -----------------------------------------------------------

    task automatic send_item(logic [7:0] b, logic e);
        while ($urandom_range(99) < in_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.text_byte    <= b;
        in_ch.end_of_input <= e;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_chunk();
        foreach (chunk[i]) send_item(chunk[i].b, chunk[i].e);
        chunk.delete();
    endtask

    task automatic random_text(int count, int long_mode, bit with_hold);
        int stop_at;
        int hold_at;
        bit held;
        stop_at = items_sent + count;
        hold_at = items_sent + count / 3;
        held    = 1'b0;
        put_long(long_mode);
        send_chunk();
        while (items_sent < stop_at) begin
            put_word();
            put_sep();
            if ($urandom_range(49) == 0) put_end();
            if ($urandom_range(199) == 0) begin
                put_end();
                put_end();
            end
            send_chunk();
            if (with_hold && !held && items_sent >= hold_at) begin
                hold_req = 1'b1;
                held     = 1'b1;
            end
        end
    endtask

    // receiver: random stalls, or one long hold-off on request
    initial begin
        tok_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                tok_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_req = 1'b0;
            end else begin
                tok_ch.ready <= ($urandom_range(99) >= out_idle_pct);
            end
        end
    end

    // both channels sampled at the edge, input first so its tokens are due in time
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready) begin
                sb.note_input(in_ch.text_byte, in_ch.end_of_input);
            end
            if (tok_ch.valid && tok_ch.ready) begin
                sb.check_token(tok_ch.token_kind, tok_ch.token_length,
                               tok_ch.line_number, tok_ch.last);
            end
            if ((in_ch.valid && in_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
        end
    end

    initial begin
        while (quiet_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("music_script_token_lexer: mismatch");
        $finish;
    end

    initial begin
        in_ch.valid        <= 1'b0;
        in_ch.text_byte    <= 8'd0;
        in_ch.end_of_input <= 1'b0;
        i_rst_n            <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        in_idle_pct  = 22;
        out_idle_pct = 58;

        // note then bracket, lone minus then bracket, all punctuation
        put_str("4C#x[");
        put_str("-]");
        put_str("{}=");
        // zero byte and top byte make a plain word
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(",");
        // end of input inside a comment with a word pending, then again
        put_str("a;z");
        put_end();
        put_end();
        // comment closed by CR LF counts two lines; bare CR counts none
        put_byte(";");
        put_byte(CH_CR);
        put_byte(CH_LF);
        put_str("9");
        put_byte(CH_TAB);
        put_byte(CH_CR);
        send_chunk();

        random_text(PHASE_ITEMS, 0, 1'b1);

        in_idle_pct  = 58;
        out_idle_pct = 22;
        random_text(PHASE_ITEMS, 1, 1'b0);

        in_idle_pct  = 0;
        out_idle_pct = 0;
        random_text(PHASE_ITEMS, 2, 1'b1);

        put_str("9 [x;c");
        put_end();
        send_chunk();
        in_ch.valid <= 1'b0;

        @(posedge i_clk);
        while (sb.due_tokens.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (sb.due_tokens.size() != 0) begin
            sb.report($sformatf("%0d tokens never came", sb.due_tokens.size()));
        end

        if (sb.errors == 0) begin
            $display("music_script_token_lexer: match");
        end else begin
            $display("music_script_token_lexer: mismatch");
        end
        $finish;
    end
endmodule

FILE: files.f
+incdir+rtl
rtl/mstl_pkg.sv
rtl/mstl_if.sv
rtl/mstl_front.sv
rtl/mstl_queue.sv
rtl/mstl_back.sv
rtl/music_script_token_lexer.sv
rtl/mstl_checker.sv
sim/tb_top.sv
